FILE: rtl/core/scet_pkg.sv
// Shared widths, constants and transfer types for the swept circle entry time block.
package scet_pkg;

   localparam int COORD_BITS  = 24;
   localparam int T_FRAC_BITS = 20;

   localparam int NUM_IN_FIELDS = 7;
   localparam int REQ_W   = ((NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8;
   localparam int T_W     = T_FRAC_BITS + 1;
   localparam int RSP_W   = ((T_W + 2 + 7) / 8) * 8;

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int RR_W    = 2 * (COORD_BITS - 1);
   localparam int SUM_W   = PROD_W + 2;
   localparam int MAG_W   = 2 * COORD_BITS + 2;
   localparam int HALF_W  = MAG_W / 2;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int RAD_W   = SQ_W + 2;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int B_W     = SUM_W;
   localparam int NUM_W   = B_W + 1;
   localparam int DEN_W   = MAG_W + 1;
   localparam int DREM_W  = DEN_W + 1;
   localparam int Q_W     = T_FRAC_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0] sx;
      logic [COORD_BITS-1:0] sz;
      logic [COORD_BITS-1:0] ex;
      logic [COORD_BITS-1:0] ez;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cz;
      logic [COORD_BITS-1:0] rad;
   } scet_coord_type;

   typedef struct packed {
      logic                    in_circle;
      logic                    miss;
      logic signed [B_W-1:0]   b;
      logic [DEN_W-1:0]        den;
   } scet_side_type;

   typedef struct packed {
      logic               valid;
      logic [RAD_W-1:0]   rad;
      scet_side_type      side;
   } scet_root_in_type;

   typedef struct packed {
      logic               valid;
      logic [ROOT_W-1:0]  s;
      scet_side_type      side;
   } scet_div_in_type;

   typedef struct packed {
      logic             valid;
      logic             in_circle;
      logic             miss;
      logic [Q_W-1:0]   q;
   } scet_result_type;

endpackage

FILE: rtl/core/scet_front.sv
// Front pipeline: differences, products, quadratic coefficients and discriminant.
module scet_front
   import scet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  scet_coord_type   in_data,
   output scet_root_in_type out
);

   function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [PROD_W-1:0] v);
      return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

   logic [6:0] valid_ff;

   // stage 1: differences
   logic signed [DIFF_W-1:0] dx_ff, dz_ff, fx_ff, fz_ff;
   logic [COORD_BITS-2:0]    r_ff;
   // stage 2: products
   logic signed [PROD_W-1:0] fxx_ff, fzz_ff, dxx_ff, dzz_ff, fxdx_ff, fzdz_ff;
   logic [RR_W-1:0]          rr_ff;
   // stage 3: coefficients
   logic signed [SUM_W-1:0]  c_ff, a_ff, h_ff;
   // stage 4: magnitudes and flags
   logic [MAG_W-1:0]         hmag_ff, amag_ff, cmag_ff;
   scet_side_type            side4_ff, side5_ff, side6_ff, side7_ff;
   logic signed [SUM_W-1:0]  habs_in;
   logic                     inside_in;
   // stage 5: partial products
   logic [MAG_W-1:0]         p_hh_ff, p_hm_ff, p_ll_ff;
   logic [MAG_W-1:0]         p_ahch_ff, p_ahcl_ff, p_alch_ff, p_alcl_ff;
   // stage 6: squares
   logic [SQ_W-1:0]          hsq_ff, ac_ff;
   // stage 7: discriminant
   logic [SQ_W:0]            d_in;
   logic [RAD_W-1:0]         rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_comb begin
      habs_in   = h_ff[SUM_W-1] ? -h_ff : h_ff;
      inside_in = c_ff[SUM_W-1] | (c_ff == '0);
      d_in      = {1'b0, hsq_ff} - {1'b0, ac_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= $signed({in_data.ex[COORD_BITS-1], in_data.ex})
                - $signed({in_data.sx[COORD_BITS-1], in_data.sx});
         dz_ff <= $signed({in_data.ez[COORD_BITS-1], in_data.ez})
                - $signed({in_data.sz[COORD_BITS-1], in_data.sz});
         fx_ff <= $signed({in_data.sx[COORD_BITS-1], in_data.sx})
                - $signed({in_data.cx[COORD_BITS-1], in_data.cx});
         fz_ff <= $signed({in_data.sz[COORD_BITS-1], in_data.sz})
                - $signed({in_data.cz[COORD_BITS-1], in_data.cz});
         // clamp a negative radius to zero
         r_ff  <= in_data.rad[COORD_BITS-1] ? '0 : in_data.rad[COORD_BITS-2:0];

         fxx_ff  <= fx_ff * fx_ff;
         fzz_ff  <= fz_ff * fz_ff;
         dxx_ff  <= dx_ff * dx_ff;
         dzz_ff  <= dz_ff * dz_ff;
         fxdx_ff <= fx_ff * dx_ff;
         fzdz_ff <= fz_ff * dz_ff;
         rr_ff   <= r_ff * r_ff;

         c_ff <= ext_sum(fxx_ff) + ext_sum(fzz_ff)
               - $signed({{(SUM_W-RR_W){1'b0}}, rr_ff});
         a_ff <= ext_sum(dxx_ff) + ext_sum(dzz_ff);
         h_ff <= ext_sum(fxdx_ff) + ext_sum(fzdz_ff);

         hmag_ff            <= habs_in[MAG_W-1:0];
         amag_ff            <= a_ff[MAG_W-1:0];
         cmag_ff            <= inside_in ? '0 : c_ff[MAG_W-1:0];
         side4_ff.in_circle <= inside_in;
         side4_ff.miss      <= (a_ff == '0);
         side4_ff.b         <= {h_ff[SUM_W-2:0], 1'b0};
         side4_ff.den       <= {a_ff[MAG_W-1:0], 1'b0};

         p_hh_ff   <= hmag_ff[MAG_W-1:HALF_W] * hmag_ff[MAG_W-1:HALF_W];
         p_hm_ff   <= hmag_ff[MAG_W-1:HALF_W] * hmag_ff[HALF_W-1:0];
         p_ll_ff   <= hmag_ff[HALF_W-1:0] * hmag_ff[HALF_W-1:0];
         p_ahch_ff <= amag_ff[MAG_W-1:HALF_W] * cmag_ff[MAG_W-1:HALF_W];
         p_ahcl_ff <= amag_ff[MAG_W-1:HALF_W] * cmag_ff[HALF_W-1:0];
         p_alch_ff <= amag_ff[HALF_W-1:0] * cmag_ff[MAG_W-1:HALF_W];
         p_alcl_ff <= amag_ff[HALF_W-1:0] * cmag_ff[HALF_W-1:0];
         side5_ff  <= side4_ff;

         hsq_ff   <= (SQ_W'(p_hh_ff) << MAG_W) + (SQ_W'(p_hm_ff) << (HALF_W + 1))
                   + SQ_W'(p_ll_ff);
         ac_ff    <= (SQ_W'(p_ahch_ff) << MAG_W)
                   + ((SQ_W'(p_ahcl_ff) + SQ_W'(p_alch_ff)) << HALF_W)
                   + SQ_W'(p_alcl_ff);
         side6_ff <= side5_ff;

         // drop negative discriminants; radicand is four times h*h - a*c
         rad_ff             <= d_in[SQ_W] ? '0 : {d_in[SQ_W-1:0], 2'b00};
         side7_ff.in_circle <= side6_ff.in_circle;
         side7_ff.miss      <= side6_ff.miss | d_in[SQ_W];
         side7_ff.b         <= side6_ff.b;
         side7_ff.den       <= side6_ff.den;
      end
   end

   assign out.valid = valid_ff[6];
   assign out.rad   = rad_ff;
   assign out.side  = side7_ff;

endmodule

FILE: rtl/core/scet_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module scet_sqrt
   import scet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  scet_root_in_type in,
   output scet_div_in_type  out
);

   logic                valid_ff [ROOT_W];
   logic [REM_W-1:0]    rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   logic [RAD_W-1:0]    rad_ff   [ROOT_W];
   scet_side_type       side_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      scet_side_type     side_prev;
      logic [REM_W-1:0]  rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              take;

      if (k == 0) begin : g_first
         assign v_prev    = in.valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in.rad;
         assign side_prev = in.side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1:RAD_W-2]};
         trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
         take    = (rem_sh >= trial);
         rem_in  = take ? rem_sh - trial : rem_sh;
         root_in = {root_prev[ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out.valid = valid_ff[ROOT_W-1];
   assign out.s     = root_ff[ROOT_W-1];
   assign out.side  = side_ff[ROOT_W-1];

endmodule

FILE: rtl/core/scet_div.sv
// Range checks and pipelined restoring divide for the entry parameter.
module scet_div
   import scet_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  scet_div_in_type in,
   output scet_result_type out
);

   logic signed [NUM_W-1:0] s_ext, b_ext, exit_in, num_in, den_ext;
   logic                    setup_valid_ff, setup_inside_ff, setup_miss_ff;
   logic [DEN_W-1:0]        setup_num_ff, setup_den_ff;

   always_comb begin
      s_ext   = $signed({{(NUM_W-ROOT_W){1'b0}}, in.s});
      b_ext   = $signed({in.side.b[B_W-1], in.side.b});
      den_ext = $signed({{(NUM_W-DEN_W){1'b0}}, in.side.den});
      exit_in = s_ext - b_ext;
      num_in  = -b_ext - s_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else if (adv) begin
         setup_valid_ff <= in.valid;
      end
   end

   // miss when the circle lies behind the start or beyond the end, or an earlier stage flagged a miss
   always_ff @(posedge clock) begin
      if (adv) begin
         setup_inside_ff <= in.side.in_circle;
         setup_miss_ff   <= in.side.miss | exit_in[NUM_W-1] | (num_in > den_ext);
         setup_num_ff    <= num_in[NUM_W-1] ? '0 : num_in[DEN_W-1:0];
         setup_den_ff    <= in.side.den;
      end
   end

   logic              valid_ff  [Q_W];
   logic              inside_ff [Q_W];
   logic              miss_ff   [Q_W];
   logic [DREM_W-1:0] rem_ff    [Q_W];
   logic [DEN_W-1:0]  den_ff    [Q_W];
   logic [Q_W-1:0]    q_ff      [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic              v_prev, inside_prev, miss_prev;
      logic [DREM_W-1:0] rem_prev, rem_sh, rem_in;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    q_prev;
      logic              ge;

      if (j == 0) begin : g_first
         assign v_prev      = setup_valid_ff;
         assign inside_prev = setup_inside_ff;
         assign miss_prev   = setup_miss_ff;
         assign rem_prev    = {1'b0, setup_num_ff};
         assign den_prev    = setup_den_ff;
         assign q_prev      = '0;
         assign rem_sh      = rem_prev;
      end else begin : g_next
         assign v_prev      = valid_ff[j-1];
         assign inside_prev = inside_ff[j-1];
         assign miss_prev   = miss_ff[j-1];
         assign rem_prev    = rem_ff[j-1];
         assign den_prev    = den_ff[j-1];
         assign q_prev      = q_ff[j-1];
         assign rem_sh      = {rem_prev[DREM_W-2:0], 1'b0};
      end

      always_comb begin
         ge     = (rem_sh >= {1'b0, den_prev});
         rem_in = ge ? rem_sh - {1'b0, den_prev} : rem_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            inside_ff[j] <= inside_prev;
            miss_ff[j]   <= miss_prev;
            rem_ff[j]    <= rem_in;
            den_ff[j]    <= den_prev;
            q_ff[j]      <= {q_prev[Q_W-2:0], ge};
         end
      end
   end

   assign out.valid     = valid_ff[Q_W-1];
   assign out.in_circle = inside_ff[Q_W-1];
   assign out.miss      = miss_ff[Q_W-1];
   assign out.q         = q_ff[Q_W-1];

endmodule

FILE: rtl/core/swept_circle_entry_time.sv
// Top level of the swept circle entry time block: segment against circle, first contact t.
// A request passes the front, square root, range check and divide pipelines, then an output
// register; the root and divider pipelines each resolve one bit per stage.
// Throughput: one request per cycle; the whole pipeline holds while a response is stalled.
// Reset: synchronous, active high; clears all valid bits, payload registers are not reset.
module swept_circle_entry_time
   import scet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // from bit 0: start_x, start_z, end_x, end_z, center_x, center_z, circle_radius
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // from bit 0: hit, entry_t, started_inside, zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   scet_coord_type   req_coord;
   scet_root_in_type front_out;
   scet_div_in_type  root_out;
   scet_result_type  div_out;
   logic             adv;

   logic             rsp_valid_ff;
   logic             hit_ff, started_ff;
   logic [T_W-1:0]   entry_t_ff;
   logic [Q_W-1:0]   q_round_in;

   // Advance every stage together whenever the output register is free or being drained.
   assign adv        = !rsp_valid_ff | rsp_tready;
   assign req_tready = adv;

   assign req_coord.sx  = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign req_coord.sz  = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign req_coord.ex  = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign req_coord.ez  = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign req_coord.cx  = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign req_coord.cz  = req_tdata[5*COORD_BITS +: COORD_BITS];
   assign req_coord.rad = req_tdata[6*COORD_BITS +: COORD_BITS];

   // Coefficients c, a, b and the radicand 4*(h*h - a*c), with h = f.d.
   scet_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_data  (req_coord),
      .out      (front_out)
   );

   // s = floor(sqrt(b*b - 4ac)).
   scet_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (front_out),
      .out   (root_out)
   );

   // Range checks, then q = floor(2^(T+1) * num / den) one bit per stage.
   scet_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (root_out),
      .out   (div_out)
   );

   // Round half up: drop the extra quotient bit after adding one.
   assign q_round_in = div_out.q + Q_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   // A start inside the circle wins over every miss condition.
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff     <= div_out.in_circle | !div_out.miss;
         started_ff <= div_out.in_circle;
         entry_t_ff <= (div_out.in_circle | div_out.miss) ? '0 : q_round_in[Q_W-1:1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-T_W-2){1'b0}}, started_ff, entry_t_ff, hit_ff};

`ifndef ASSERT_OFF
   // A miss carries no contact time and no inside flag.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit_ff) |-> (entry_t_ff == '0 && !started_ff))
      else $error("miss with nonzero payload");

   // A start inside the circle is a hit at t = 0.
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && started_ff) |-> (hit_ff && entry_t_ff == '0))
      else $error("inside start without zero entry time");

   // The contact time never exceeds one.
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (entry_t_ff <= T_W'(1 << T_FRAC_BITS)))
      else $error("entry time above one");
`endif

endmodule
